/* hw/rtl/htlp_pkg.sv */
// Shared types, constants and the FNV-1a round for the linear-probe hash table.
// Used by htlp_ctrl, htlp_dp and hash_table_linear_probe; no dependencies.
package htlp_pkg;

   localparam int SLOTS_DEF      = 1024;
   localparam int VALUE_BITS_DEF = 64;

   localparam int KEY_W         = 64;
   localparam int VALUE_PORT_W  = 64;
   localparam int KEY_BYTES_W   = 4;
   localparam int STATUS_W      = 3;
   localparam int SLOT_IDX_W    = 10;
   localparam int ENTRY_W       = 11;

   localparam logic [KEY_BYTES_W-1:0] KEY_BYTES_RESET = 4'd8;
   localparam logic [KEY_BYTES_W-1:0] KEY_BYTES_MAX   = 4'd8;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_FOUND    = 3'd2,
      ST_MISSING  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      logic       load;      // capture request item
      logic       hash;      // one FNV round
      logic       seed;      // start slot from final hash
      logic       rd;        // read slot at probe position
      logic       next;      // advance probe / clear position
      logic       clr_wr;    // clear sweep write
      logic       ins_wr;    // claim empty slot
      logic       upd_wr;    // overwrite value in place
      logic       rsp_load;  // load result register
      status_type rsp_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_round;
      logic clear_last;
      logic lookup;
      logic rd_used;
      logic rd_match;
      logic full;
      logic last_probe;
   } dp_stat_type;

   // h' = (h ^ b) * 0x100000001b3, prime split as 2^40 + 0x1b3 shift-adds
   function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] t;
      t = h ^ {56'd0, b};
      return (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
   endfunction

   // byte lanes below n kept
   function automatic logic [KEY_W-1:0] key_mask(input logic [KEY_BYTES_W-1:0] n);
      logic [KEY_W-1:0] m;
      for (int b = 0; b < KEY_W / 8; b++) begin
         m[8*b +: 8] = (KEY_BYTES_W'(b) < n) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

endpackage

/* hw/rtl/hash_table_linear_probe.sv */
// Linear-probe hash table, FNV-1a over key_bytes bytes. An item runs n hash rounds,
// one per key byte, then p probes, each one registered memory read plus a compare.
// A new item is taken only once the previous result is in the result register, which
// waits while an earlier result is unread. The load limit is 75 percent. After reset
// the slot memory is swept clear, one slot per cycle, before the first item is taken;
// csr writes are taken during the sweep. Depends on htlp_pkg, htlp_ctrl, htlp_dp.
module hash_table_linear_probe
   import htlp_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_kind,
   input  logic [KEY_W-1:0]        req_key,
   input  logic [VALUE_PORT_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [VALUE_PORT_W-1:0] rsp_found_value,
   output logic [SLOT_IDX_W-1:0]   rsp_slot_index,
   output logic [ENTRY_W-1:0]      rsp_entry_total,
   input  logic                    csr_wr_en,
   input  logic [KEY_BYTES_W-1:0]  csr_wr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   htlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   htlp_dp #(
      .SLOTS      (SLOTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .req_value       (req_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_entry_total (rsp_entry_total)
   );

endmodule

/* hw/rtl/htlp_ctrl.sv */
// Sequencer for the hash table: clear sweep, hash rounds, probe loop, result hand-off.
// Depends on htlp_pkg; drives htlp_dp through ctrl_cmd_type, watches dp_stat_type.
module htlp_ctrl
   import htlp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd,
   input  dp_stat_type  stat
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_RD,
      S_CMP
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       resolve;
   logic       do_ins, do_upd;
   status_type st;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.rsp_status = ST_MISSING;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      resolve      = 1'b0;
      do_ins       = 1'b0;
      do_upd       = 1'b0;
      st           = ST_MISSING;

      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            cmd.next   = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash = 1'b1;
            if (stat.last_round) begin
               cmd.seed = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!stat.rd_used) begin
               resolve = 1'b1;
               if (stat.lookup) st = ST_MISSING;
               else if (stat.full) st = ST_FULL;
               else begin
                  st     = ST_INSERTED;
                  do_ins = 1'b1;
               end
            end else if (stat.rd_match) begin
               resolve = 1'b1;
               st      = stat.lookup ? ST_FOUND : ST_UPDATED;
               do_upd  = !stat.lookup;
            end else if (stat.last_probe) begin
               // wrapped all the way round without an empty slot
               resolve = 1'b1;
               st      = stat.lookup ? ST_MISSING : ST_FULL;
            end

            if (resolve) begin
               // hold here with the read data until the result register frees up
               if (out_free) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = st;
                  cmd.ins_wr     = do_ins;
                  cmd.upd_wr     = do_upd;
                  rsp_valid_in   = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.next = 1'b1;
               state_in = S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/htlp_dp.sv */
// Datapath for the hash table: key length register, FNV hash, slot memory, compare,
// entry count and result register. Depends on htlp_pkg; controlled by htlp_ctrl.
module htlp_dp
   import htlp_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dp_stat_type             stat,
   input  logic                    req_kind,
   input  logic [KEY_W-1:0]        req_key,
   input  logic [VALUE_PORT_W-1:0] req_value,
   input  logic                    csr_wr_en,
   input  logic [KEY_BYTES_W-1:0]  csr_wr_data,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [VALUE_PORT_W-1:0] rsp_found_value,
   output logic [SLOT_IDX_W-1:0]   rsp_slot_index,
   output logic [ENTRY_W-1:0]      rsp_entry_total
);

   localparam int IW    = $clog2(SLOTS);
   localparam int LIMIT = SLOTS * 3 / 4;
   localparam int CW    = $clog2(LIMIT + 1);
   localparam int MEM_W = 1 + KEY_W + VALUE_BITS;

   // key length register
   logic [KEY_BYTES_W-1:0] key_bytes_ff;
   logic [KEY_BYTES_W-1:0] nbytes_sel;

   always_comb begin
      if (key_bytes_ff == '0) nbytes_sel = KEY_BYTES_W'(1);
      else if (key_bytes_ff > KEY_BYTES_MAX) nbytes_sel = KEY_BYTES_MAX;
      else nbytes_sel = key_bytes_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) key_bytes_ff <= KEY_BYTES_RESET;
      else if (csr_wr_en) key_bytes_ff <= csr_wr_data;
   end

   // request capture and hash
   logic                   kind_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [VALUE_BITS-1:0]  value_ff;
   logic [KEY_BYTES_W-1:0] nbytes_ff;
   logic [2:0]             round_ff;
   logic [63:0]            hash_ff, hash_in;
   logic [KEY_W-1:0]       kmask;

   assign kmask   = key_mask(nbytes_ff);
   assign hash_in = fnv_round(hash_ff, key_ff[{round_ff, 3'b000} +: 8]);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         key_ff    <= req_key & key_mask(nbytes_sel);
         value_ff  <= req_value[VALUE_BITS-1:0];
         nbytes_ff <= nbytes_sel;
         round_ff  <= '0;
         hash_ff   <= FNV_BASIS;
      end else if (cmd.hash) begin
         round_ff <= round_ff + 3'd1;
         hash_ff  <= hash_in;
      end
   end

   // probe position doubles as the clear sweep address after reset
   logic [IW-1:0] pos_ff;
   logic [IW-1:0] steps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         steps_ff <= '0;
      end else if (cmd.seed) begin
         pos_ff   <= hash_in[IW-1:0];
         steps_ff <= '0;
      end else if (cmd.next) begin
         pos_ff   <= pos_ff + IW'(1);
         steps_ff <= steps_ff + IW'(1);
      end
   end

   // slot memory: {used, key, value}
   logic [MEM_W-1:0]      mem [SLOTS];
   logic [MEM_W-1:0]      rd_q;
   logic [MEM_W-1:0]      wdata;
   logic                  we;
   logic [KEY_W-1:0]      rd_key;
   logic [VALUE_BITS-1:0] rd_val;

   assign rd_key = rd_q[VALUE_BITS +: KEY_W];
   assign rd_val = rd_q[VALUE_BITS-1:0];
   assign we     = cmd.clr_wr || cmd.ins_wr || cmd.upd_wr;

   always_comb begin
      if (cmd.clr_wr) wdata = '0;
      else if (cmd.upd_wr) wdata = {1'b1, rd_key, value_ff};  // stored key kept as is
      else wdata = {1'b1, key_ff, value_ff};
   end

   always_ff @(posedge clock) begin
      if (we) mem[pos_ff] <= wdata;
      if (cmd.rd) rd_q <= mem[pos_ff];
   end

   // occupancy
   logic [CW-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.ins_wr) count_ff <= count_ff + CW'(1);
   end

   assign stat.last_round = ({1'b0, round_ff} == nbytes_ff - KEY_BYTES_W'(1));
   assign stat.clear_last = (pos_ff == '1);
   assign stat.lookup     = (kind_ff == KIND_LOOKUP);
   assign stat.rd_used    = rd_q[MEM_W-1];
   assign stat.rd_match   = (((rd_key ^ key_ff) & kmask) == '0);
   assign stat.full       = (count_ff >= CW'(LIMIT));
   assign stat.last_probe = (steps_ff == '1);

   // result register
   logic [STATUS_W-1:0]     status_ff;
   logic [VALUE_PORT_W-1:0] found_ff;
   logic [SLOT_IDX_W-1:0]   slot_ff;
   logic [ENTRY_W-1:0]      total_ff;
   logic                    has_slot;

   assign has_slot = (cmd.rsp_status == ST_INSERTED) || (cmd.rsp_status == ST_UPDATED)
                     || (cmd.rsp_status == ST_FOUND);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff <= cmd.rsp_status;
         found_ff  <= (cmd.rsp_status == ST_FOUND) ? VALUE_PORT_W'(rd_val) : '0;
         slot_ff   <= has_slot ? SLOT_IDX_W'(pos_ff) : '0;
         total_ff  <= cmd.ins_wr ? ENTRY_W'(count_ff + CW'(1)) : ENTRY_W'(count_ff);
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found_value = found_ff;
   assign rsp_slot_index  = slot_ff;
   assign rsp_entry_total = total_ff;

endmodule

/* tb/sv/tb_hash_table_linear_probe.sv */
// Self-checking testbench for hash_table_linear_probe: inserts and lookups over several
// key lengths, random idling on both channels, filled to the load limit.
// Depends on htlp_pkg and the hash_table_linear_probe RTL.

typedef struct packed {
   htlp_pkg::status_type                   status;
   logic [htlp_pkg::VALUE_PORT_W-1:0]      found_value;
   logic [htlp_pkg::SLOT_IDX_W-1:0]        slot;
   logic [htlp_pkg::ENTRY_W-1:0]           total;
} table_reply_type;

// Shadow copy of the slot store; predicts one reply per accepted request.
class table_scoreboard;
   localparam int SLOT_COUNT = htlp_pkg::SLOTS_DEF;
   localparam logic [63:0] FNV_MULT = 64'h0000_0100_0000_01b3;

   bit                            slot_busy [SLOT_COUNT];
   logic [htlp_pkg::KEY_W-1:0]    slot_key_copy [SLOT_COUNT];
   logic [htlp_pkg::VALUE_PORT_W-1:0] slot_val_copy [SLOT_COUNT];
   int unsigned                   occupied;
   logic [htlp_pkg::KEY_BYTES_W-1:0] key_len;
   table_reply_type               awaiting[$];
   int unsigned                   errors;
   int unsigned                   full_seen;

   function new();
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      occupied  = 0;
      key_len   = htlp_pkg::KEY_BYTES_RESET;
      errors    = 0;
      full_seen = 0;
   endfunction

   function logic [63:0] fnv_digest(logic [63:0] k, int unsigned n);
      logic [63:0] h;
      h = htlp_pkg::FNV_BASIS;
      for (int b = 0; b < n; b++) begin
         h = (h ^ {56'd0, k[8*b +: 8]}) * FNV_MULT;
      end
      return h;
   endfunction

   task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   function void note_request(logic kind, logic [63:0] key, logic [63:0] value);
      table_reply_type r;
      int unsigned  n;
      logic [63:0]  km;
      logic [63:0]  k;
      int unsigned  pos;
      bit           settled;
      // length 0 behaves as 1, anything above 8 as 8
      n = (key_len == 0) ? 1 : ((key_len > 8) ? 8 : key_len);
      km = '0;
      for (int b = 0; b < 8; b++) begin
         if (b < n) km[8*b +: 8] = 8'hff;
      end
      k = key & km;
      pos = int'(fnv_digest(k, n) % 64'(SLOT_COUNT));
      r.found_value = '0;
      r.slot        = '0;
      r.status      = (kind == htlp_pkg::KIND_LOOKUP) ? htlp_pkg::ST_MISSING : htlp_pkg::ST_FULL;
      settled = 1'b0;
      for (int step = 0; step < SLOT_COUNT && !settled; step++) begin
         if (!slot_busy[pos]) begin
            settled = 1'b1;
            if (kind == htlp_pkg::KIND_LOOKUP) begin
               r.status = htlp_pkg::ST_MISSING;
            end else if ((occupied + 1) * 4 > SLOT_COUNT * 3) begin
               r.status = htlp_pkg::ST_FULL;
            end else begin
               slot_busy[pos]     = 1'b1;
               slot_key_copy[pos] = k;
               slot_val_copy[pos] = value;
               occupied++;
               r.status = htlp_pkg::ST_INSERTED;
               r.slot   = htlp_pkg::SLOT_IDX_W'(pos);
            end
         end else if (((slot_key_copy[pos] ^ k) & km) == '0) begin
            settled = 1'b1;
            r.slot  = htlp_pkg::SLOT_IDX_W'(pos);
            if (kind == htlp_pkg::KIND_LOOKUP) begin
               r.status      = htlp_pkg::ST_FOUND;
               r.found_value = slot_val_copy[pos];
            end else begin
               slot_val_copy[pos] = value;
               r.status           = htlp_pkg::ST_UPDATED;
            end
         end else begin
            pos = (pos + 1) % SLOT_COUNT;
         end
      end
      r.total = htlp_pkg::ENTRY_W'(occupied);
      if (r.status == htlp_pkg::ST_FULL) full_seen++;
      awaiting.push_back(r);
   endfunction

   task check_result(logic [2:0] status, logic [63:0] fv, logic [9:0] slot, logic [10:0] total);
      table_reply_type want;
      if (awaiting.size() == 0) begin
         report($sformatf("reply with nothing outstanding: status %0d slot %0d", status, slot));
         return;
      end
      want = awaiting.pop_front();
      if (status !== want.status)
         report($sformatf("status got %0d want %0d", status, want.status));
      if (fv !== want.found_value)
         report($sformatf("found_value got %h want %h", fv, want.found_value));
      if (slot !== want.slot)
         report($sformatf("slot_index got %0d want %0d", slot, want.slot));
      if (total !== want.total)
         report($sformatf("entry_total got %0d want %0d", total, want.total));
   endtask
endclass

module tb_hash_table_linear_probe;
   import htlp_pkg::*;

   localparam int LIMIT_CYCLES = 2_000_000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_kind;
   logic [KEY_W-1:0]        req_key;
   logic [VALUE_PORT_W-1:0] req_value;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [STATUS_W-1:0]     rsp_status;
   logic [VALUE_PORT_W-1:0] rsp_found_value;
   logic [SLOT_IDX_W-1:0]   rsp_slot_index;
   logic [ENTRY_W-1:0]      rsp_entry_total;
   logic                    csr_wr_en;
   logic [KEY_BYTES_W-1:0]  csr_wr_data;

   table_scoreboard book;
   logic [63:0]     key_pool[$];
   int unsigned     send_idle_pct;
   int unsigned     stall_pct;
   int unsigned     hold_left;
   int unsigned     cycle_count;

   hash_table_linear_probe u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_entry_total (rsp_entry_total),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_result(rsp_status, rsp_found_value, rsp_slot_index, rsp_entry_total);
      if (!reset && req_valid && req_ready)
         book.note_request(req_kind, req_key, req_value);
   end

   function automatic logic [63:0] pick_word();
      logic [63:0] w;
      case ($urandom_range(9))
         0: w = '0;
         1: w = '1;
         2: begin
            for (int b = 0; b < 8; b++) w[8*b +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
         end
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   task automatic send_item(input logic kind, input logic [63:0] key, input logic [63:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_key   <= key;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // block is idle once every reply is back; every item yields a reply
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.awaiting.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_key_len(input logic [KEY_BYTES_W-1:0] len);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      book.key_len = len;
   endtask

   task automatic run_phase(input int unsigned items, input int unsigned fresh_pct,
                            input bit to_full);
      int unsigned i;
      int unsigned roll;
      logic [63:0] k;
      i = 0;
      while (i < items || (to_full && book.full_seen < 12 && i < 3 * items)) begin
         roll = $urandom_range(99);
         if (roll < fresh_pct || key_pool.size() == 0) begin
            k = pick_word();
            key_pool.push_back(k);
            send_item(KIND_INSERT, k, pick_word());
         end else begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
            case (roll % 6)
               0, 1:    send_item(KIND_INSERT, k, pick_word());
               2, 3, 4: send_item(KIND_LOOKUP, k, pick_word());
               default: send_item(KIND_LOOKUP, pick_word(), pick_word());
            endcase
         end
         i++;
      end
   endtask

   initial begin
      book          = new();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_INSERT;
      req_key       = '0;
      req_value     = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extreme keys and values, update in place
      write_key_len(4'd8);
      send_item(KIND_LOOKUP, '0, '0);
      send_item(KIND_INSERT, '0, '1);
      send_item(KIND_INSERT, '1, '0);
      send_item(KIND_LOOKUP, '0, pick_word());
      send_item(KIND_LOOKUP, '1, pick_word());
      send_item(KIND_INSERT, '0, 64'h5555_5555_5555_5555);
      send_item(KIND_LOOKUP, '0, '0);
      send_item(KIND_INSERT, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000);
      send_item(KIND_LOOKUP, 64'h8000_0000_0000_0000, '0);
      drain();
      // one-byte keys while 8-byte entries are live; upper bytes ignored
      write_key_len(4'd1);
      send_item(KIND_INSERT, 64'h12, 64'ha5);
      send_item(KIND_LOOKUP, 64'hffff_ff12, '0);
      send_item(KIND_LOOKUP, '0, '0);
      send_item(KIND_INSERT, 64'hff00, 64'h1);
      drain();
      // zero length behaves as one byte
      write_key_len(4'd0);
      send_item(KIND_LOOKUP, {$urandom, $urandom} & 64'hffff_ffff_ffff_ff00 | 64'h12, '0);
      send_item(KIND_INSERT, 64'hab12, 64'h7);
      drain();
      // lengths above 8 behave as 8
      write_key_len(4'd15);
      send_item(KIND_LOOKUP, '1, '0);
      send_item(KIND_LOOKUP, 64'h12, '0);
      drain();
      write_key_len(4'd9);
      send_item(KIND_INSERT, 64'h12, 64'h9);
      send_item(KIND_LOOKUP, '0, '0);
      drain();

      write_key_len(4'd8);
      send_idle_pct = 0;
      stall_pct     = 0;
      run_phase(250, 65, 1'b0);
      drain();

      write_key_len(4'd1);
      send_idle_pct = 47;
      stall_pct     = 0;
      run_phase(150, 50, 1'b0);
      drain();

      // long hold-off on the reply side so the request side backs up
      write_key_len(4'd4);
      send_idle_pct = 0;
      stall_pct     = 47;
      hold_left     = 600;
      run_phase(200, 65, 1'b0);
      drain();

      write_key_len(4'd2);
      send_idle_pct = 32;
      stall_pct     = 32;
      run_phase(250, 60, 1'b0);
      drain();

      // push past the load limit; updates must still go through
      write_key_len(4'd15);
      send_idle_pct = 0;
      stall_pct     = 0;
      run_phase(300, 85, 1'b1);
      drain();

      repeat (20) @(posedge clock);
      if (book.awaiting.size() != 0)
         book.report($sformatf("%0d replies never arrived", book.awaiting.size()));
      if (book.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* hash_table_linear_probe.f */
hw/rtl/htlp_pkg.sv
hw/rtl/htlp_ctrl.sv
hw/rtl/htlp_dp.sv
hw/rtl/hash_table_linear_probe.sv
tb/sv/tb_hash_table_linear_probe.sv
